// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ipac_pkg.sv =====
// types and constants of the prefix access check block
`default_nettype none

package ipac_pkg;

  localparam int ADDR_W  = 8;
  localparam int NET_W   = 128;
  localparam int ENTRY_W = NET_W + 1;
  localparam int V4_BASE = 129;
  localparam int MEM_DEPTH = 162;

  localparam logic [7:0] V4_MAX = 8'd32;
  localparam logic [7:0] V6_MAX = 8'd128;
  localparam logic [ADDR_W-1:0] V4_OFFSET = ADDR_W'(V4_BASE);

  localparam logic [1:0] REQ_CHECK = 2'd0;
  localparam logic [1:0] REQ_ADD   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] STS_GRANTED   = 3'd0;
  localparam logic [2:0] STS_METHOD_NA = 3'd1;
  localparam logic [2:0] STS_FORBIDDEN = 3'd2;
  localparam logic [2:0] STS_STORED    = 3'd3;
  localparam logic [2:0] STS_TOO_LONG  = 3'd4;
  localparam logic [2:0] STS_TAKEN     = 3'd5;
  localparam logic [2:0] STS_CLEARED   = 3'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic               en;
    logic [ADDR_W-1:0]  addr;
    logic [ENTRY_W-1:0] data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/ipac_if.sv =====
// channel interfaces of the prefix access check block
`default_nettype none

interface ipac_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        is_v6;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [7:0]  prefix_len;
  logic        rule_allow;
  logic [2:0]  method_code;

  modport source (output valid, req_type, is_v6, addr_hi, addr_lo, prefix_len,
                  rule_allow, method_code, input ready);
  modport sink (input valid, req_type, is_v6, addr_hi, addr_lo, prefix_len,
                rule_allow, method_code, output ready);
endinterface

interface ipac_resp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       range_hit;
  logic [7:0] hit_prefix;

  modport source (output valid, status, range_hit, hit_prefix, input ready);
  modport sink (input valid, status, range_hit, hit_prefix, output ready);
endinterface

interface ipac_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] method_mask;

  modport source (output valid, method_mask, input ready);
  modport sink (input valid, method_mask, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ipac_rule_mem.sv =====
// rule table memory, one write port and one registered read port
`default_nettype none

module ipac_rule_mem (
  input  wire logic                           clk,
  input  wire ipac_pkg::mem_wr_t              wr,
  input  wire logic [ipac_pkg::ADDR_W-1:0]    rd_addr,
  output logic      [ipac_pkg::ENTRY_W-1:0]   rd_data
);

  logic [ipac_pkg::ENTRY_W-1:0] mem [ipac_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/ip_prefix_access_check.sv =====
// top level of the longest prefix access check engine
//
// req carries one item: check access, add a rule or clear both rule tables.
// resp returns exactly one item per request: status, range_hit, hit_prefix.
// cfg writes method_mask at any edge with valid high; ready is always high.
// Add, clear and a check with an empty method mask go from EXEC straight to
// FINISH and then to resp valid. Other checks walk the rule table of the
// family from the longest prefix down to prefix 0, one slot per cycle
// through the single read port of the rule memory and one masked compare,
// and stop early on a hit. req.ready is high only while no item is in
// work, so one item is handled at a time; req.ready rises in the same
// cycle as resp valid, so the next item can be taken while resp valid is high.
// The result sits in an output register; a new item is taken while it
// waits, and the next result waits until resp.ready frees it.
// Reset clears all valid bits, method_mask and both channels at once, so
// the block accepts an item in the first cycle after reset.
`default_nettype none
`include "assert_macros.svh"

module ip_prefix_access_check #(
  parameter int METHOD_COUNT = 8
) (
  input wire logic   clk,
  input wire logic   rst,
  ipac_req_if.sink   req,
  ipac_resp_if.source resp,
  ipac_cfg_if.sink   cfg
);

  localparam logic [4:0] METHOD_LIMIT = 5'(METHOD_COUNT);

  ipac_pkg::state_t state, state_next;

  logic [7:0]   method_mask;
  logic [1:0]   op_type;
  logic         op_v6;
  logic [127:0] op_addr;
  logic [7:0]   op_plen;
  logic         op_allow;
  logic [2:0]   op_code;

  logic [32:0]  v4_valid;
  logic [128:0] v6_valid;

  logic [7:0]   rd_idx;
  logic         rd_live;
  logic         cmp_live;
  logic [7:0]   cmp_idx;
  logic         cmp_valid;
  logic [127:0] mask;

  logic [2:0]   res_status;
  logic         res_hit;
  logic [7:0]   res_prefix;

  logic         out_valid;
  logic [2:0]   out_status;
  logic         out_hit;
  logic [7:0]   out_prefix;

  ipac_pkg::mem_wr_t                  mem_wr;
  logic [ipac_pkg::ADDR_W-1:0]        mem_rd_addr;
  logic [ipac_pkg::ENTRY_W-1:0]       mem_rd_data;

  logic [7:0]   fam_max;
  logic         plen_bad;
  logic         slot_taken;
  logic         listed;
  logic         rd_valid_bit;
  logic [127:0] net;
  logic         cmp_any;
  logic         cmp_match;
  logic         scan_end;
  logic         out_free;
  logic         scan_start;
  logic [2:0]   exec_status;
  logic [2:0]   scan_status;

  ipac_rule_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  assign fam_max  = op_v6 ? ipac_pkg::V6_MAX : ipac_pkg::V4_MAX;
  assign plen_bad = op_plen > fam_max;
  assign slot_taken = op_v6 ? v6_valid[op_plen] : v4_valid[op_plen[5:0]];
  assign listed = ({2'b00, op_code} < METHOD_LIMIT) && method_mask[op_code];
  assign scan_start = (op_type == ipac_pkg::REQ_CHECK) && (method_mask != 8'd0);

  assign mem_rd_addr  = op_v6 ? rd_idx : rd_idx + ipac_pkg::V4_OFFSET;
  assign rd_valid_bit = op_v6 ? v6_valid[rd_idx] : v4_valid[rd_idx[5:0]];

  // masked compare on the top aligned address
  assign net       = mem_rd_data[127:0];
  assign cmp_any   = (cmp_idx == fam_max) && (net == 128'd0);
  assign cmp_match = cmp_live && cmp_valid && (cmp_any || (((op_addr ^ net) & mask) == '0));
  assign scan_end  = cmp_live && (cmp_match || (cmp_idx == 8'd0));

  assign out_free = !out_valid || resp.ready;

  always_comb begin
    if (cmp_match && listed) begin
      scan_status = ipac_pkg::STS_GRANTED;
    end else if (cmp_match && mem_rd_data[128]) begin
      scan_status = ipac_pkg::STS_METHOD_NA;
    end else begin
      scan_status = ipac_pkg::STS_FORBIDDEN;
    end
  end

  always_comb begin
    case (op_type)
      ipac_pkg::REQ_CHECK: exec_status = ipac_pkg::STS_GRANTED;
      ipac_pkg::REQ_ADD: begin
        if (plen_bad) begin
          exec_status = ipac_pkg::STS_TOO_LONG;
        end else if (slot_taken) begin
          exec_status = ipac_pkg::STS_TAKEN;
        end else begin
          exec_status = ipac_pkg::STS_STORED;
        end
      end
      ipac_pkg::REQ_CLEAR: exec_status = ipac_pkg::STS_CLEARED;
      default: exec_status = ipac_pkg::STS_FORBIDDEN;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ipac_pkg::S_IDLE: begin
        if (req.valid) begin
          state_next = ipac_pkg::S_EXEC;
        end
      end
      ipac_pkg::S_EXEC: begin
        state_next = scan_start ? ipac_pkg::S_SCAN : ipac_pkg::S_FINISH;
      end
      ipac_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = ipac_pkg::S_FINISH;
        end
      end
      ipac_pkg::S_FINISH: begin
        if (out_free) begin
          state_next = ipac_pkg::S_IDLE;
        end
      end
      default: state_next = ipac_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready   = (state == ipac_pkg::S_IDLE);
    cfg.ready   = 1'b1;
    mem_wr.en   = (state == ipac_pkg::S_EXEC) && (op_type == ipac_pkg::REQ_ADD) &&
                  !plen_bad && !slot_taken;
    mem_wr.addr = op_v6 ? op_plen : op_plen + ipac_pkg::V4_OFFSET;
    mem_wr.data = {op_allow, op_addr};
  end

  assign resp.valid      = out_valid;
  assign resp.status     = out_status;
  assign resp.range_hit  = out_hit;
  assign resp.hit_prefix = out_prefix;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ipac_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      method_mask <= 8'd0;
    end else if (cfg.valid && cfg.ready) begin
      method_mask <= cfg.method_mask;
    end
  end

  // capture of the accepted item
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      op_type  <= req.req_type;
      op_v6    <= req.is_v6;
      op_addr  <= req.is_v6 ? {req.addr_hi, req.addr_lo} : {req.addr_lo[31:0], 96'd0};
      op_plen  <= req.prefix_len;
      op_allow <= req.rule_allow;
      op_code  <= req.method_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4_valid <= '0;
      v6_valid <= '0;
    end else if (state == ipac_pkg::S_EXEC) begin
      if (op_type == ipac_pkg::REQ_CLEAR) begin
        v4_valid <= '0;
        v6_valid <= '0;
      end else if (mem_wr.en) begin
        if (op_v6) begin
          v6_valid[op_plen] <= 1'b1;
        end else begin
          v4_valid[op_plen[5:0]] <= 1'b1;
        end
      end
    end
  end

  // slot walk: read stage then compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_live  <= 1'b0;
      cmp_live <= 1'b0;
    end else if (state == ipac_pkg::S_EXEC) begin
      rd_live  <= 1'b1;
      cmp_live <= 1'b0;
    end else if (state == ipac_pkg::S_SCAN) begin
      rd_live  <= rd_live && (rd_idx != 8'd0);
      cmp_live <= rd_live && !scan_end;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ipac_pkg::S_EXEC) begin
      rd_idx <= fam_max;
      mask   <= op_v6 ? '1 : {32'hFFFF_FFFF, 96'd0};
    end else if (state == ipac_pkg::S_SCAN) begin
      rd_idx    <= rd_idx - 8'd1;
      cmp_idx   <= rd_idx;
      cmp_valid <= rd_valid_bit;
      if (cmp_live) begin
        mask <= {mask[126:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ipac_pkg::S_EXEC) begin
      res_status <= exec_status;
      res_hit    <= 1'b0;
      res_prefix <= 8'd0;
    end else if (state == ipac_pkg::S_SCAN && scan_end) begin
      res_status <= scan_status;
      res_hit    <= cmp_match;
      res_prefix <= cmp_match ? cmp_idx : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ipac_pkg::S_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (resp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ipac_pkg::S_FINISH && out_free) begin
      out_status <= res_status;
      out_hit    <= res_hit;
      out_prefix <= res_prefix;
    end
  end

  `ASSERT_IMPLY(a_miss_no_prefix, clk, rst, out_valid && !out_hit, out_prefix == 8'd0)
  `ASSERT_IMPLY(a_hit_is_check, clk, rst, out_valid && out_hit,
                out_status == ipac_pkg::STS_GRANTED || out_status == ipac_pkg::STS_METHOD_NA ||
                out_status == ipac_pkg::STS_FORBIDDEN)
  `ASSERT_NEXT(a_add_sets_valid, clk, rst, mem_wr.en,
               (op_v6 && v6_valid[op_plen]) || (!op_v6 && v4_valid[op_plen[5:0]]))
  `ASSERT_IMPLY(a_scan_in_range, clk, rst, state == ipac_pkg::S_SCAN && cmp_live,
                cmp_idx <= fam_max)

endmodule

`default_nettype wire
